// ===== hw/rtl/wave_surface_displace_defines.svh =====
// Assertion macros for the wave surface block
`ifndef WAVE_SURFACE_DISPLACE_DEFINES_SVH
`define WAVE_SURFACE_DISPLACE_DEFINES_SVH
`ifndef SYNTHESIS
`define WSD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WSD_ASSERT_IMPL(lbl, ante, cons, msg)
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/wsd_pkg.sv =====
`timescale 1ns / 1ps
package wsd_pkg;
    localparam int MAX_WAVES    = 16;
    localparam int FRAC_BITS    = 16;
    localparam int IDX_W        = $clog2(MAX_WAVES);
    localparam int CNT_W        = $clog2(MAX_WAVES + 1);
    localparam int QUO_W        = 2 * FRAC_BITS + 1;
    localparam int CORDIC_STEPS = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic {
        CFG_WAVE_COUNT = 1'b0,
        CFG_TIME_NOW   = 1'b1
    } cfg_index_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction
endpackage

// ===== hw/rtl/wave_surface_displace.sv =====
`timescale 1ns / 1ps
// Wave surface displacement, Q16.16.
// Request channel in_valid/in_ready carries op, slot and arg_0..arg_7.
// op 0 loads a wave slot (wavelength, speed, amplitude, steepness, dir x/z);
// it gives no result, and in_ready returns once the bit-serial divider
// has turned the wavelength into a wave number.
// op 1 displaces a vertex and gives one result on out_valid/out_ready:
// new_x, new_y, new_z and wave_height, summing n = min(wave_count, 16) waves.
// Each wave makes seven passes through the one shared 33x33 multiplier
// and also waits on the iterative CORDIC.
// One request is worked on at a time; in_ready is high only when idle.
// A finished result sits in the output register; a new request is taken
// while it waits, but the next result holds until the receiver takes it.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 wave_count,
// 1 time_now) and cfg_data; cfg_ready is always high. Write only when idle.
// Reset clears the control state, wave_count and time_now; wave tables
// are undefined until loaded.
module wave_surface_displace
    import wsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [3:0]         slot,
    input  logic signed [31:0] arg_0,
    input  logic signed [31:0] arg_1,
    input  logic signed [31:0] arg_2,
    input  logic signed [31:0] arg_3,
    input  logic signed [31:0] arg_4,
    input  logic signed [31:0] arg_5,
    input  logic signed [31:0] arg_6,
    input  logic signed [31:0] arg_7,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_x,
    output logic signed [31:0] new_y,
    output logic signed [31:0] new_z,
    output logic signed [31:0] wave_height
);
`include "wave_surface_displace_defines.svh"

    typedef enum logic [17:0] {
        ST_IDLE = 18'h00001,
        ST_DIV  = 18'h00002,
        ST_DX   = 18'h00004,
        ST_DZ   = 18'h00008,
        ST_ST   = 18'h00010,
        ST_U    = 18'h00020,
        ST_PH   = 18'h00040,
        ST_CS   = 18'h00080,
        ST_CORD = 18'h00100,
        ST_SDS  = 18'h00200,
        ST_INN  = 18'h00400,
        ST_AMP  = 18'h00800,
        ST_ACC  = 18'h01000,
        ST_OX   = 18'h02000,
        ST_OY   = 18'h04000,
        ST_OZ   = 18'h08000,
        ST_OW   = 18'h10000,
        ST_OUT  = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    logic [4:0]         wave_count_reg;
    logic signed [31:0] time_now_reg;
    logic signed [31:0] arg_reg [8];
    logic [3:0]         slot_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   n_waves;

    logic signed [31:0] k_tbl [MAX_WAVES];
    logic signed [31:0] spd_tbl [MAX_WAVES];
    logic signed [31:0] amp_tbl [MAX_WAVES];
    logic signed [31:0] stp_tbl [MAX_WAVES];
    logic signed [31:0] dx_tbl [MAX_WAVES];
    logic signed [31:0] dz_tbl [MAX_WAVES];

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;
    logic signed [65:0] prod_sh;
    logic signed [31:0] prod_q;

    logic signed [49:0] a1_reg;
    logic signed [31:0] d_reg, st_reg, sd_reg, inner_reg, h_reg;
    logic signed [31:0] xr_reg, yr_reg, zr_reg;
    logic signed [32:0] u_val;

    logic               div_start, div_done;
    logic [31:0]        div_mag;
    logic [QUO_W-1:0]   quo;
    logic signed [31:0] wnum;

    logic               cor_start, cor_done;
    logic signed [31:0] cos_val, sin_val;

    logic               accept, out_load;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign n_waves   = (wave_count_reg > 5'(MAX_WAVES)) ? CNT_W'(MAX_WAVES)
                                                       : CNT_W'(wave_count_reg);
    assign prod_sh   = prod_reg >>> FRAC_BITS;
    assign prod_q    = sat32(prod_sh);
    assign u_val     = 33'(d_reg) + 33'(st_reg);
    assign div_start = accept && !op;
    assign div_mag   = arg_0[31] ? 32'(-arg_0) : 32'(arg_0);
    assign cor_start = (state_reg == ST_CS);
    assign out_load  = (state_reg == ST_OUT) && (!out_valid || out_ready);

    always_comb
    begin
        if (arg_reg[0] == 32'sd0)
            wnum = 32'sh7fffffff;
        else if (!arg_reg[0][31])
            wnum = (quo > QUO_W'(32'h7fffffff)) ? 32'sh7fffffff : quo[31:0];
        else
            wnum = (quo >= QUO_W'(32'h80000000)) ? 32'sh80000000 : 32'(-quo[31:0]);
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DX:
            begin
                mul_a = 33'(arg_reg[0]);
                mul_b = 33'(dx_tbl[idx_reg]);
            end
            ST_DZ:
            begin
                mul_a = 33'(arg_reg[1]);
                mul_b = 33'(dz_tbl[idx_reg]);
            end
            ST_ST:
            begin
                mul_a = 33'(spd_tbl[idx_reg]);
                mul_b = 33'(time_now_reg);
            end
            ST_U:
            begin
                mul_a = 33'(stp_tbl[idx_reg]);
                mul_b = 33'(d_reg);
            end
            ST_PH:
            begin
                mul_a = 33'(k_tbl[idx_reg]);
                mul_b = u_val;
            end
            ST_SDS:
            begin
                mul_a = 33'(sd_reg);
                mul_b = 33'(sin_val);
            end
            ST_AMP:
            begin
                mul_a = 33'(amp_tbl[idx_reg]);
                mul_b = 33'(inner_reg);
            end
            ST_OX:
            begin
                mul_a = 33'(arg_reg[5]);
                mul_b = 33'(h_reg);
            end
            ST_OY:
            begin
                mul_a = 33'(arg_reg[6]);
                mul_b = 33'(h_reg);
            end
            ST_OZ:
            begin
                mul_a = 33'(arg_reg[7]);
                mul_b = 33'(h_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (!op)
                        state_next = ST_DIV;
                    else if (n_waves == '0)
                        state_next = ST_OX;
                    else
                        state_next = ST_DX;
                end
            ST_DIV:  if (div_done) state_next = ST_IDLE;
            ST_DX:   state_next = ST_DZ;
            ST_DZ:   state_next = ST_ST;
            ST_ST:   state_next = ST_U;
            ST_U:    state_next = ST_PH;
            ST_PH:   state_next = ST_CS;
            ST_CS:   state_next = ST_CORD;
            ST_CORD: if (cor_done) state_next = ST_SDS;
            ST_SDS:  state_next = ST_INN;
            ST_INN:  state_next = ST_AMP;
            ST_AMP:  state_next = ST_ACC;
            ST_ACC:
                if (CNT_W'(idx_reg) + CNT_W'(1) == n_waves)
                    state_next = ST_OX;
                else
                    state_next = ST_DX;
            ST_OX:   state_next = ST_OY;
            ST_OY:   state_next = ST_OZ;
            ST_OZ:   state_next = ST_OW;
            ST_OW:   state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid      <= 1'b0;
            wave_count_reg <= '0;
            time_now_reg   <= '0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_WAVE_COUNT)
                    wave_count_reg <= cfg_data[4:0];
                else
                    time_now_reg <= cfg_data;
            end
            if (out_load)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
            if (accept)
                idx_reg <= '0;
            else if (state_reg == ST_ACC)
                idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (accept)
        begin
            arg_reg[0] <= arg_0;
            arg_reg[1] <= arg_1;
            arg_reg[2] <= arg_2;
            arg_reg[3] <= arg_3;
            arg_reg[4] <= arg_4;
            arg_reg[5] <= arg_5;
            arg_reg[6] <= arg_6;
            arg_reg[7] <= arg_7;
            slot_reg   <= slot;
            h_reg      <= '0;
        end
        if (state_reg == ST_DIV && div_done && 32'(slot_reg) < 32'(MAX_WAVES))
        begin
            k_tbl[IDX_W'(slot_reg)]   <= wnum;
            spd_tbl[IDX_W'(slot_reg)] <= arg_reg[1];
            amp_tbl[IDX_W'(slot_reg)] <= arg_reg[2];
            stp_tbl[IDX_W'(slot_reg)] <= arg_reg[3];
            dx_tbl[IDX_W'(slot_reg)]  <= arg_reg[4];
            dz_tbl[IDX_W'(slot_reg)]  <= arg_reg[5];
        end
        case (state_reg)
            ST_DZ:  a1_reg    <= prod_sh[49:0];
            ST_ST:  d_reg     <= sat32(66'(a1_reg) + prod_sh);
            ST_U:   st_reg    <= prod_q;
            ST_PH:  sd_reg    <= prod_q;
            ST_INN: inner_reg <= sat32(66'(cos_val) + 66'(prod_q));
            ST_ACC: h_reg     <= sat32(66'(h_reg) + 66'(prod_q));
            ST_OY:  xr_reg    <= sat32(66'(arg_reg[2]) + prod_sh);
            ST_OZ:  yr_reg    <= sat32(66'(arg_reg[3]) + prod_sh);
            ST_OW:  zr_reg    <= sat32(66'(arg_reg[4]) + prod_sh);
            default: ;
        endcase
        if (out_load)
        begin
            new_x       <= xr_reg;
            new_y       <= yr_reg;
            new_z       <= zr_reg;
            wave_height <= h_reg;
        end
    end

    wsd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (div_mag),
        .done  (div_done),
        .quo   (quo)
    );

    // phase is the fraction of a turn from k*u
    wsd_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .phase   (prod_reg[2*FRAC_BITS-1:FRAC_BITS]),
        .done    (cor_done),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    `WSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
    `WSD_ASSERT_IMPL(a_cor_done, cor_done, state_reg == ST_CORD, "stray cordic done")
    `WSD_ASSERT_IMPL(a_div_done, div_done, state_reg == ST_DIV, "stray divider done")
    `WSD_ASSERT_NEXT(a_one_req, accept, !in_ready, "request taken while busy")
endmodule

// ===== hw/rtl/wsd_div.sv =====
`timescale 1ns / 1ps
module wsd_div
    import wsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [31:0]      mag,
    output logic             done,
    output logic [QUO_W-1:0] quo
);
    logic [31:0]      rem_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [31:0]      mag_reg;
    logic [32:0]      rs;
    logic             ge;

    // restoring division of 2^(2*FRAC_BITS), one quotient bit per cycle
    assign rs = {rem_reg, (cnt_reg == 6'(2 * FRAC_BITS))};
    assign ge = rs >= {1'b0, mag_reg};
    assign quo = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(2 * FRAC_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            mag_reg <= mag;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 32'(rs - {1'b0, mag_reg}) : rs[31:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end
endmodule

// ===== hw/rtl/wsd_cordic.sv =====
`timescale 1ns / 1ps
module wsd_cordic
    import wsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [FRAC_BITS-1:0] phase,
    output logic                 done,
    output logic signed [31:0]   cos_val,
    output logic signed [31:0]   sin_val
);
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [4:0]         step_reg;
    logic               busy_reg;
    logic               flip_reg;
    logic [31:0]        ang;
    logic signed [33:0] z0, sx, sy, at, fx, fy;

    assign ang = {phase, {(32 - FRAC_BITS){1'b0}}};
    assign z0  = 34'(signed'(ang));
    assign sx  = x_reg >>> step_reg;
    assign sy  = y_reg >>> step_reg;
    assign at  = 34'(atan_turn(step_reg));
    assign fx  = flip_reg ? -x_reg : x_reg;
    assign fy  = flip_reg ? -y_reg : y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == 5'(CORDIC_STEPS))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                else
                    step_reg <= step_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
            // fold into +-quarter turn, negate at the end
            if (z0 > 34'sd1073741824)
            begin
                z_reg    <= z0 - 34'sd2147483648;
                flip_reg <= 1'b1;
            end
            else if (z0 < -34'sd1073741824)
            begin
                z_reg    <= z0 + 34'sd2147483648;
                flip_reg <= 1'b1;
            end
            else
            begin
                z_reg    <= z0;
                flip_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (step_reg == 5'(CORDIC_STEPS))
            begin
                cos_val <= sat32(66'(fx >>> (30 - FRAC_BITS)));
                sin_val <= sat32(66'(fy >>> (30 - FRAC_BITS)));
            end
            else if (!z_reg[33])
            begin
                x_reg <= x_reg - sy;
                y_reg <= y_reg + sx;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + sy;
                y_reg <= y_reg - sx;
                z_reg <= z_reg + at;
            end
        end
    end
endmodule

// ===== tb/sv/tb_wave_surface_displace.sv =====
`timescale 1ns / 1ps
module tb_wave_surface_displace;
    import wsd_pkg::*;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_VERTEX = 1'b1;
    localparam int   N_DIRECTED = 24;
    localparam int   FIRST_WAVE_ROW = 18;
    localparam int   N_PHASES = 10;
    localparam int   SETTLE_CYCLES = 50;
    localparam logic signed [31:0] QMAX = 32'sh7fffffff;
    localparam logic signed [31:0] QMIN = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh00010000;

    typedef struct {
        logic               op;
        logic [3:0]         slot;
        logic signed [31:0] arg [8];
    } wave_req_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] h;
    } displaced_t;

    typedef struct {
        wave_req_t  req;
        bit         typed;
        displaced_t res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [31:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic op;
    logic [3:0] slot;
    logic signed [31:0] arg_0, arg_1, arg_2, arg_3, arg_4, arg_5, arg_6, arg_7;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] new_x, new_y, new_z, wave_height;

    // predictor state
    logic signed [31:0] wave_k     [MAX_WAVES];
    logic signed [31:0] wave_speed [MAX_WAVES];
    logic signed [31:0] wave_amp   [MAX_WAVES];
    logic signed [31:0] wave_steep [MAX_WAVES];
    logic signed [31:0] wave_dirx  [MAX_WAVES];
    logic signed [31:0] wave_dirz  [MAX_WAVES];
    logic [4:0]         cur_count;
    logic signed [31:0] cur_time;

    displaced_t displaced_q[$];
    stim_row_t  directed [N_DIRECTED];
    int fails;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;

    wave_surface_displace i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .slot(slot),
        .arg_0(arg_0), .arg_1(arg_1), .arg_2(arg_2), .arg_3(arg_3),
        .arg_4(arg_4), .arg_5(arg_5), .arg_6(arg_6), .arg_7(arg_7),
        .out_valid(out_valid), .out_ready(out_ready),
        .new_x(new_x), .new_y(new_y), .new_z(new_z), .wave_height(wave_height)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return QMAX;
        if (v < -64'sd2147483648)
            return QMIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fix_mul(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return clip32((longint'(a) * longint'(b)) >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] wave_number_of(input logic signed [31:0] wl);
        longint mag;
        if (wl == 0)
            return QMAX;
        mag = (64'sd1 <<< (2 * FRAC_BITS)) / (wl > 0 ? longint'(wl) : -longint'(wl));
        if (wl > 0)
            return mag > 64'sd2147483647 ? QMAX : mag[31:0];
        return mag >= 64'sd2147483648 ? QMIN : clip32(-mag);
    endfunction

    task automatic turn_sincos(input logic [FRAC_BITS-1:0] ph,
                               output logic signed [31:0] c,
                               output logic signed [31:0] s);
        longint arc [CORDIC_STEPS];
        longint z, x, y, nx;
        bit flip;
        arc = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10679838, 5340245, 2670163, 1335087, 667544, 333772,
                166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304,
                652, 326, 163, 81};
        z = longint'($signed({ph, {(32 - FRAC_BITS){1'b0}}}));
        flip = 1'b0;
        x = longint'(CORDIC_GAIN);
        y = 0;
        if (z > 64'sd1073741824)
        begin
            z -= 64'sd2147483648;
            flip = 1'b1;
        end
        else if (z < -64'sd1073741824)
        begin
            z += 64'sd2147483648;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= arc[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += arc[i];
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = clip32(x >>> (30 - FRAC_BITS));
        s = clip32(y >>> (30 - FRAC_BITS));
    endtask

    task automatic displace_vertex(input wave_req_t r, output displaced_t res);
        int n;
        logic signed [31:0] h, d, st, sd, sds, inner, term, c, s;
        longint u, prod;
        n = cur_count > MAX_WAVES ? MAX_WAVES : int'(cur_count);
        h = 0;
        for (int i = 0; i < n; i++)
        begin
            d = clip32(((longint'(r.arg[0]) * longint'(wave_dirx[i])) >>> FRAC_BITS)
                     + ((longint'(r.arg[1]) * longint'(wave_dirz[i])) >>> FRAC_BITS));
            st = fix_mul(wave_speed[i], cur_time);
            u = longint'(d) + longint'(st);
            prod = longint'(wave_k[i]) * u;
            turn_sincos(prod[2*FRAC_BITS-1:FRAC_BITS], c, s);
            sd = fix_mul(wave_steep[i], d);
            sds = fix_mul(sd, s);
            inner = clip32(longint'(c) + longint'(sds));
            term = fix_mul(wave_amp[i], inner);
            h = clip32(longint'(h) + longint'(term));
        end
        res.x = clip32(longint'(r.arg[2]) + ((longint'(r.arg[5]) * longint'(h)) >>> FRAC_BITS));
        res.y = clip32(longint'(r.arg[3]) + ((longint'(r.arg[6]) * longint'(h)) >>> FRAC_BITS));
        res.z = clip32(longint'(r.arg[4]) + ((longint'(r.arg[7]) * longint'(h)) >>> FRAC_BITS));
        res.h = h;
    endtask

    // Update tables on a load, queue the expected displacement on a vertex.
    task automatic accept_request(input stim_row_t row);
        displaced_t res;
        if (row.req.op == OP_LOAD)
        begin
            wave_k[row.req.slot]     = wave_number_of(row.req.arg[0]);
            wave_speed[row.req.slot] = row.req.arg[1];
            wave_amp[row.req.slot]   = row.req.arg[2];
            wave_steep[row.req.slot] = row.req.arg[3];
            wave_dirx[row.req.slot]  = row.req.arg[4];
            wave_dirz[row.req.slot]  = row.req.arg[5];
        end
        else
        begin
            if (row.typed)
                res = row.res;
            else
                displace_vertex(row.req, res);
            displaced_q.push_back(res);
        end
    endtask

    task automatic send_request(input stim_row_t row);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        op    <= row.req.op;
        slot  <= row.req.slot;
        arg_0 <= row.req.arg[0];
        arg_1 <= row.req.arg[1];
        arg_2 <= row.req.arg[2];
        arg_3 <= row.req.arg[3];
        arg_4 <= row.req.arg[4];
        arg_5 <= row.req.arg[5];
        arg_6 <= row.req.arg[6];
        arg_7 <= row.req.arg[7];
        do
            @(posedge clk);
        while (!in_ready);
        accept_request(row);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_WAVE_COUNT)
            cur_count = data[4:0];
        else
            cur_time = data;
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (displaced_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [4:0] count, input logic signed [31:0] t);
        write_reg(CFG_WAVE_COUNT, {27'd0, count});
        write_reg(CFG_TIME_NOW, t);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // mostly small values so that the waves do not all saturate
    function automatic logic signed [31:0] rand_fix();
        if ($urandom_range(3) == 0)
            return $urandom;
        return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    endfunction

    function automatic stim_row_t rand_row();
        stim_row_t row;
        row.req.op = $urandom_range(4) == 0 ? OP_LOAD : OP_VERTEX;
        row.req.slot = $urandom_range(15);
        for (int i = 0; i < 8; i++)
            row.req.arg[i] = rand_fix();
        row.typed = 1'b0;
        row.res = '{default: '0};
        return row;
    endfunction

    function automatic stim_row_t mk_row(input logic o, input logic [3:0] sl,
                                         input logic signed [31:0] a0, a1, a2, a3,
                                         input logic signed [31:0] a4, a5, a6, a7);
        stim_row_t row;
        row.req.op = o;
        row.req.slot = sl;
        row.req.arg = '{a0, a1, a2, a3, a4, a5, a6, a7};
        row.typed = 1'b0;
        row.res = '{default: '0};
        return row;
    endfunction

    always @(posedge clk)
    begin
        displaced_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (displaced_q.size() == 0)
            begin
                $error("result with no request outstanding");
                fails++;
            end
            else
            begin
                exp_r = displaced_q.pop_front();
                if (new_x !== exp_r.x)
                begin
                    $error("new_x expected %0d got %0d", exp_r.x, new_x);
                    fails++;
                end
                if (new_y !== exp_r.y)
                begin
                    $error("new_y expected %0d got %0d", exp_r.y, new_y);
                    fails++;
                end
                if (new_z !== exp_r.z)
                begin
                    $error("new_z expected %0d got %0d", exp_r.z, new_z);
                    fails++;
                end
                if (wave_height !== exp_r.h)
                begin
                    $error("wave_height expected %0d got %0d", exp_r.h, wave_height);
                    fails++;
                end
            end
        end
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles--;
        end
        else
            out_ready <= $urandom_range(99) >= recv_stall_pct;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int idle_mode [4][2];
        logic [4:0] ph_count [N_PHASES];
        int ph_items [N_PHASES];
        logic signed [31:0] ph_time [N_PHASES];

        idle_mode = '{'{0, 0}, '{87, 0}, '{0, 87}, '{32, 32}};
        ph_count = '{5'd1, 5'd2, 5'd3, 5'd16, 5'd4, 5'd31, 5'd2, 5'd0, 5'd17, 5'd5};
        ph_items = '{200, 200, 200, 30, 180, 25, 200, 100, 25, 240};
        ph_time = '{0, $urandom, QMAX, $urandom, QMIN, $urandom, $urandom, 0,
                    $urandom, $urandom};

        fails = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WAVE_COUNT;
        cfg_data = '0;
        in_valid = 1'b0;
        op = OP_LOAD;
        slot = '0;
        {arg_0, arg_1, arg_2, arg_3, arg_4, arg_5, arg_6, arg_7} = '0;
        out_ready = 1'b0;
        cur_count = '0;
        cur_time = '0;

        // vertices before any wave is summed: rest position, zero height
        directed[0] = mk_row(OP_VERTEX, 4'd0, QMAX, QMIN, ONE, 2 * ONE, -3 * ONE,
                             QMAX, QMIN, QMAX);
        directed[0].typed = 1'b1;
        directed[0].res = '{ONE, 2 * ONE, -3 * ONE, 0};
        directed[1] = mk_row(OP_VERTEX, 4'd15, QMIN, QMAX, QMAX, QMIN, QMAX,
                             QMIN, QMAX, QMIN);
        directed[1].typed = 1'b1;
        directed[1].res = '{QMAX, QMIN, QMAX, 0};
        // wavelength zero, negative, tiny, extremes, then ordinary waves
        directed[2]  = mk_row(OP_LOAD, 4'd0, 0, ONE, ONE, ONE, ONE, 0, QMAX, QMIN);
        directed[3]  = mk_row(OP_LOAD, 4'd1, -1, -ONE, ONE / 2, QMAX, 0, ONE, 0, 0);
        directed[4]  = mk_row(OP_LOAD, 4'd2, 1, QMAX, QMAX, QMIN, QMAX, QMIN, 0, 0);
        directed[5]  = mk_row(OP_LOAD, 4'd3, QMIN, QMIN, QMIN, 0, QMIN, QMAX, 0, 0);
        directed[6]  = mk_row(OP_LOAD, 4'd4, QMAX, 0, ONE, ONE / 4, ONE, ONE, 0, 0);
        directed[7]  = mk_row(OP_LOAD, 4'd5, ONE, 2 * ONE, ONE / 8, ONE / 2, -ONE, 0, 0, 0);
        directed[8]  = mk_row(OP_LOAD, 4'd6, 4 * ONE, ONE, ONE / 4, 0, 0, -ONE, 0, 0);
        directed[9]  = mk_row(OP_LOAD, 4'd7, -4 * ONE, ONE, ONE / 4, ONE, ONE, ONE, 0, 0);
        directed[10] = mk_row(OP_LOAD, 4'd8, 8 * ONE, 3 * ONE, ONE / 16, ONE, ONE / 2,
                              ONE / 2, 0, 0);
        directed[11] = mk_row(OP_LOAD, 4'd9, ONE / 2, -ONE, ONE / 10, ONE / 3, 0, ONE, 0, 0);
        directed[12] = mk_row(OP_LOAD, 4'd10, 16 * ONE, ONE / 2, ONE / 5, 0, ONE, 0, 0, 0);
        directed[13] = mk_row(OP_LOAD, 4'd11, 3 * ONE, ONE, -ONE / 4, ONE / 2, -ONE,
                              -ONE, 0, 0);
        directed[14] = mk_row(OP_LOAD, 4'd12, 32 * ONE, 2 * ONE, ONE / 8, ONE, ONE / 3,
                              ONE / 3, 0, 0);
        directed[15] = mk_row(OP_LOAD, 4'd13, 6 * ONE, ONE / 4, ONE / 16, 2 * ONE, 0,
                              -ONE, 0, 0);
        directed[16] = mk_row(OP_LOAD, 4'd14, 10 * ONE, ONE, ONE / 32, ONE, ONE, 0, 0, 0);
        directed[17] = mk_row(OP_LOAD, 4'd15, 5 * ONE, -2 * ONE, ONE / 8, ONE / 4, ONE / 2,
                              -ONE / 2, 0, 0);
        directed[18] = mk_row(OP_VERTEX, 4'd0, 0, 0, 0, 0, 0, 0, ONE, 0);
        directed[19] = mk_row(OP_VERTEX, 4'd0, ONE, 2 * ONE, ONE, 0, 2 * ONE, 0, ONE, 0);
        directed[20] = mk_row(OP_VERTEX, 4'd0, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX);
        directed[21] = mk_row(OP_VERTEX, 4'd0, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN);
        directed[22] = mk_row(OP_VERTEX, 4'd0, -ONE / 2, 3 * ONE, 0, 0, 0, ONE / 3, ONE,
                              -ONE / 3);
        directed[23] = mk_row(OP_VERTEX, 4'd0, 7 * ONE, -5 * ONE, 7 * ONE, 0, -5 * ONE,
                              0, ONE, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        configure(5'd0, 0);

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            if (r == FIRST_WAVE_ROW)
            begin
                drain_and_settle();
                configure(5'd16, ONE * 3 / 2);
            end
            send_request(directed[r]);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_and_settle();
            configure(ph_count[p], ph_time[p]);
            send_idle_pct = idle_mode[p % 4][0];
            recv_stall_pct = idle_mode[p % 4][1];
            // long receiver hold-off so the output stalls and backs up the input
            if (p == 1)
                hold_cycles = 2000;
            for (int k = 0; k < ph_items[p]; k++)
                send_request(rand_row());
        end

        drain_and_settle();
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
